@@ rtl/core/assert_macros.svh @@
// assertion macros shared by the deframer modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define SLDF_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication
`define SLDF_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`else
`define SLDF_ASSERT_IMPL(label, clk, rst, ante, cons, msg)
`define SLDF_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif
`endif

@@ rtl/core/sldf_pkg.sv @@
// types, constants and helpers for the sync/length/checksum deframer
package sldf_pkg;

  localparam int HEADER_BYTES = 4;
  localparam int CNT_W        = 9;
  localparam int IDX_W        = 3;
  localparam int CFG_INDEX_W  = 1;

  // byte_count values while the header is taken in
  localparam logic [CNT_W-1:0] HDR_SYNC = CNT_W'(0);
  localparam logic [CNT_W-1:0] HDR_CODE = CNT_W'(1);
  localparam logic [CNT_W-1:0] HDR_LEN  = CNT_W'(2);
  localparam logic [CNT_W-1:0] HDR_SUM  = CNT_W'(3);

  // configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_SYNC    = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] REG_SUM_ERR = 1'b1;

  // error reply byte indexes
  localparam logic [1:0] REPLY_SYNC  = 2'd0;
  localparam logic [1:0] REPLY_CODE  = 2'd1;
  localparam logic [1:0] REPLY_ZERO  = 2'd2;
  localparam logic [1:0] REPLY_ERROR = 2'd3;

  typedef enum logic [1:0] {
    KIND_PAYLOAD = 2'd0,
    KIND_GOOD    = 2'd1,
    KIND_REPLY   = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    FIN_NONE = 2'd0,
    FIN_GOOD = 2'd1,
    FIN_BAD  = 2'd2
  } fin_t;

  // everything the result sequencer needs for one input byte
  typedef struct packed {
    logic       pay_valid;
    logic [7:0] pay_byte;
    logic [7:0] pay_pos;
    fin_t       fin;
    logic [7:0] code;
    logic [7:0] length;
  } sldf_desc_t;

  // number of result words a descriptor stands for
  function automatic logic [IDX_W-1:0] desc_count(sldf_desc_t d);
    logic [IDX_W-1:0] n;
    n = {{(IDX_W-1){1'b0}}, d.pay_valid};
    case (d.fin)
      FIN_GOOD: n = n + IDX_W'(1);
      FIN_BAD:  n = n + IDX_W'(4);
      default:  n = n;
    endcase
    return n;
  endfunction

endpackage

@@ rtl/core/sldf_in_if.sv @@
// input byte channel
interface sldf_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

@@ rtl/core/sldf_out_if.sv @@
// result word channel
interface sldf_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] data_byte;
  logic [7:0] frame_code;
  logic [7:0] frame_length;
  logic [7:0] position;
  logic       last;

  modport source (output valid, output kind, output data_byte, output frame_code,
                  output frame_length, output position, output last, input ready);
  modport sink   (input valid, input kind, input data_byte, input frame_code,
                  input frame_length, input position, input last, output ready);
endinterface

@@ rtl/core/sync_length_sum_deframer_core.sv @@
// top level of the sync/length/checksum deframer
//
// Channels: in_ch takes one received byte per word (rx_byte); out_ch gives
// result words (kind, data_byte, frame_code, frame_length, position, last).
// Both use valid/ready; a word moves when both are high at a clock edge.
// The cfg port writes sync_reg (index 0) and sum_err_reg (index 1)
// whenever cfg_we is high; write only while no results are pending.
// The first result of a byte appears in the cycle after the byte is taken.
// Throughput: one byte per cycle while each byte yields at most one word
// and out_ch is ready; a byte that closes a frame yields up to five words
// (payload plus four reply words) and the next byte is taken together
// with its last word, as all words leave through the single output port.
// Reset (rst, synchronous) clears the frame state to hunting for sync and
// zeroes both configuration registers.
// A stalled receiver holds the current word steady; in_ch.ready stays low
// until the last pending word is being taken.
module sync_length_sum_deframer_core (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [sldf_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [7:0]                       cfg_data,
  sldf_in_if.sink                          in_ch,
  sldf_out_if.source                       out_ch
);

  logic                 sync_value;
  logic [7:0]           sync_reg;
  logic [7:0]           sum_err_reg;
  logic                 in_fire;
  logic                 emit_ready;
  sldf_pkg::sldf_desc_t desc;

  assign sync_value = (in_ch.rx_byte == sync_reg);
  assign in_ch.ready = emit_ready;
  assign in_fire     = in_ch.valid && emit_ready;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      sync_reg    <= 8'd0;
      sum_err_reg <= 8'd0;
    end else if (cfg_we) begin
      case (cfg_index)
        sldf_pkg::REG_SYNC:    sync_reg    <= cfg_data;
        sldf_pkg::REG_SUM_ERR: sum_err_reg <= cfg_data;
        default:               sync_reg    <= sync_reg;
      endcase
    end
  end

  sldf_frame u_frame (
    .clk        (clk),
    .rst        (rst),
    .fire       (in_fire),
    .rx_byte    (in_ch.rx_byte),
    .sync_value (sync_value ? in_ch.rx_byte : sync_reg),
    .desc       (desc)
  );

  sldf_emit u_emit (
    .clk           (clk),
    .rst           (rst),
    .in_fire       (in_fire),
    .desc_in       (desc),
    .in_ready      (emit_ready),
    .sync_value    (sync_reg),
    .sum_err_value (sum_err_reg),
    .out_ch        (out_ch)
  );

endmodule

@@ rtl/core/sldf_frame.sv @@
// frame tracker: header capture, payload count and running sum
`include "assert_macros.svh"

module sldf_frame (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              fire,
  input  logic [7:0]                        rx_byte,
  input  logic [7:0]                        sync_value,
  output sldf_pkg::sldf_desc_t              desc
);

  logic [sldf_pkg::CNT_W-1:0] byte_count;
  logic [sldf_pkg::CNT_W-1:0] byte_count_next;
  logic [7:0]                 held_code;
  logic [7:0]                 held_code_next;
  logic [7:0]                 held_length;
  logic [7:0]                 held_length_next;
  logic [7:0]                 held_checksum;
  logic [7:0]                 held_checksum_next;
  logic [7:0]                 running_sum;
  logic [7:0]                 running_sum_next;

  logic [sldf_pkg::CNT_W-1:0] count_inc;
  logic [sldf_pkg::CNT_W-1:0] pay_index;
  logic [7:0]                 sum_pay;
  logic [sldf_pkg::CNT_W:0]   frame_end;
  logic                       end_reached;

  // payload arithmetic
  assign count_inc   = byte_count + sldf_pkg::CNT_W'(1);
  assign pay_index   = byte_count - sldf_pkg::CNT_W'(sldf_pkg::HEADER_BYTES);
  assign sum_pay     = running_sum + rx_byte;
  assign frame_end   = {2'b00, held_length} + (sldf_pkg::CNT_W+1)'(sldf_pkg::HEADER_BYTES);
  assign end_reached = ({1'b0, count_inc} >= frame_end) ||
                       (count_inc < sldf_pkg::CNT_W'(sldf_pkg::HEADER_BYTES));

  // next frame state and descriptor for this byte
  always_comb begin
    byte_count_next    = byte_count;
    held_code_next     = held_code;
    held_length_next   = held_length;
    held_checksum_next = held_checksum;
    running_sum_next   = running_sum;
    desc.pay_valid     = 1'b0;
    desc.pay_byte      = rx_byte;
    desc.pay_pos       = pay_index[7:0];
    desc.fin           = sldf_pkg::FIN_NONE;
    case (byte_count)
      sldf_pkg::HDR_SYNC: begin
        if (rx_byte == sync_value) begin
          byte_count_next  = sldf_pkg::HDR_CODE;
          running_sum_next = 8'd0;
        end
      end
      sldf_pkg::HDR_CODE: begin
        held_code_next  = rx_byte;
        byte_count_next = sldf_pkg::HDR_LEN;
      end
      sldf_pkg::HDR_LEN: begin
        held_length_next = rx_byte;
        byte_count_next  = sldf_pkg::HDR_SUM;
      end
      sldf_pkg::HDR_SUM: begin
        held_checksum_next = rx_byte;
        running_sum_next   = 8'd0;
        byte_count_next    = sldf_pkg::CNT_W'(sldf_pkg::HEADER_BYTES);
        // empty payload closes the frame on the checksum byte
        if (held_length == 8'd0) begin
          desc.fin        = (rx_byte == 8'd0) ? sldf_pkg::FIN_GOOD : sldf_pkg::FIN_BAD;
          byte_count_next = sldf_pkg::HDR_SYNC;
        end
      end
      default: begin
        desc.pay_valid = 1'b1;
        if (end_reached) begin
          desc.fin         = (sum_pay == held_checksum) ? sldf_pkg::FIN_GOOD
                                                        : sldf_pkg::FIN_BAD;
          byte_count_next  = sldf_pkg::HDR_SYNC;
          running_sum_next = 8'd0;
        end else begin
          byte_count_next  = count_inc;
          running_sum_next = sum_pay;
        end
      end
    endcase
    desc.code   = held_code_next;
    desc.length = held_length_next;
  end

  // frame state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count    <= sldf_pkg::HDR_SYNC;
      held_code     <= 8'd0;
      held_length   <= 8'd0;
      held_checksum <= 8'd0;
      running_sum   <= 8'd0;
    end else if (fire) begin
      byte_count    <= byte_count_next;
      held_code     <= held_code_next;
      held_length   <= held_length_next;
      held_checksum <= held_checksum_next;
      running_sum   <= running_sum_next;
    end
  end

  // checks
  `SLDF_ASSERT_IMPL(a_count_in_frame, clk, rst,
    byte_count >= sldf_pkg::CNT_W'(sldf_pkg::HEADER_BYTES),
    {1'b0, byte_count} < frame_end, "payload count beyond frame end")
  `SLDF_ASSERT_NEXT(a_finish_hunts, clk, rst,
    fire && (desc.fin != sldf_pkg::FIN_NONE),
    (byte_count == sldf_pkg::HDR_SYNC) && (running_sum == 8'd0),
    "finished frame did not return to hunting")
  `SLDF_ASSERT_IMPL(a_sum_clear_in_header, clk, rst,
    byte_count < sldf_pkg::CNT_W'(sldf_pkg::HEADER_BYTES),
    running_sum == 8'd0, "running sum not clear outside payload")

endmodule

@@ rtl/core/sldf_emit.sv @@
// result sequencer: holds one descriptor and sends its words in order
`include "assert_macros.svh"

module sldf_emit (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_fire,
  input  sldf_pkg::sldf_desc_t desc_in,
  output logic                 in_ready,
  input  logic [7:0]           sync_value,
  input  logic [7:0]           sum_err_value,
  sldf_out_if.source           out_ch
);

  logic                         busy;
  logic [sldf_pkg::IDX_W-1:0]   idx;
  sldf_pkg::sldf_desc_t         desc;

  logic [sldf_pkg::IDX_W-1:0]   word_cnt;
  logic [sldf_pkg::IDX_W-1:0]   reply_idx;
  logic                         is_last;
  logic                         out_fire;
  logic                         load;
  sldf_pkg::kind_t              kind;

  assign word_cnt  = sldf_pkg::desc_count(desc);
  assign reply_idx = idx - {{(sldf_pkg::IDX_W-1){1'b0}}, desc.pay_valid};
  assign is_last   = (idx == word_cnt - sldf_pkg::IDX_W'(1));
  assign out_fire  = out_ch.valid && out_ch.ready;
  assign in_ready  = !busy || (out_ch.ready && is_last);
  assign load      = in_fire && (sldf_pkg::desc_count(desc_in) != '0);

  // select the current word
  always_comb begin
    kind             = sldf_pkg::KIND_PAYLOAD;
    out_ch.data_byte = desc.pay_byte;
    out_ch.position  = desc.pay_pos;
    if (!(desc.pay_valid && (idx == '0))) begin
      case (desc.fin)
        sldf_pkg::FIN_GOOD: begin
          kind             = sldf_pkg::KIND_GOOD;
          out_ch.data_byte = 8'd0;
          out_ch.position  = 8'd0;
        end
        sldf_pkg::FIN_BAD: begin
          kind            = sldf_pkg::KIND_REPLY;
          out_ch.position = {6'd0, reply_idx[1:0]};
          case (reply_idx[1:0])
            sldf_pkg::REPLY_SYNC:  out_ch.data_byte = sync_value;
            sldf_pkg::REPLY_CODE:  out_ch.data_byte = desc.code;
            sldf_pkg::REPLY_ZERO:  out_ch.data_byte = 8'd0;
            sldf_pkg::REPLY_ERROR: out_ch.data_byte = sum_err_value;
            default:               out_ch.data_byte = 8'd0;
          endcase
        end
        default: begin
          kind = sldf_pkg::KIND_PAYLOAD;
        end
      endcase
    end
  end

  assign out_ch.valid        = busy;
  assign out_ch.kind         = kind;
  assign out_ch.frame_code   = desc.code;
  assign out_ch.frame_length = desc.length;
  assign out_ch.last         = is_last;

  // sequencer control, a new descriptor takes over from the last word
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      idx  <= '0;
    end else if (load) begin
      busy <= 1'b1;
      idx  <= '0;
    end else if (out_fire) begin
      if (is_last) begin
        busy <= 1'b0;
      end else begin
        idx <= idx + sldf_pkg::IDX_W'(1);
      end
    end
  end

  // descriptor holding register
  always_ff @(posedge clk) begin
    if (load) begin
      desc <= desc_in;
    end
  end

  // checks
  `SLDF_ASSERT_IMPL(a_idx_in_range, clk, rst,
    busy, idx < word_cnt, "word index past descriptor end")
  `SLDF_ASSERT_NEXT(a_drain_idle, clk, rst,
    out_fire && is_last && !load, !busy, "sequencer busy after last word")
  `SLDF_ASSERT_IMPL(a_good_is_last, clk, rst,
    busy && (kind == sldf_pkg::KIND_GOOD), is_last, "good frame word not last")

endmodule
